// ===== hw/rtl/lzhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lzhd_pkg;

	localparam int DICT_AW = 12;
	localparam int POS_W = 32;

	localparam logic [1:0] MODE_PASS   = 2'd0;
	localparam logic [1:0] MODE_DIRECT = 2'd1;

	localparam logic [15:0] HASH_MULT = 16'h9E5F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       fault;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic f_lo;
		logic f_hi;
		logic m1;
		logic lit;
		logic m2;
		logic dict_rd;
		logic dict_cap;
		logic m_rd;
		logic m_xfer;
		logic post;
		logic h_rd;
		logic h_cap;
		logic h_mul;
		logic h_set;
		logic h_next;
		logic fin_set;
		logic restart;
		logic out_match;
	} lzhd_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       flag0;
		logic       flag_last;
		logic [1:0] lit_run;
		logic       match_end;
		logic       last;
		logic       pass;
	} lzhd_sts_t;

	function automatic logic [7:0] default_char(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0, 5'd10:  c = 8'h31;
			5'd1, 5'd11:  c = 8'h32;
			5'd2, 5'd12:  c = 8'h33;
			5'd3, 5'd13:  c = 8'h34;
			5'd4, 5'd14:  c = 8'h35;
			5'd5, 5'd15:  c = 8'h36;
			5'd6, 5'd16:  c = 8'h37;
			5'd7, 5'd17:  c = 8'h38;
			5'd8:         c = 8'h39;
			5'd9:         c = 8'h30;
			default:      c = 8'h30;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lzhd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzhd_ctrl import lzhd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire lzhd_sts_t st,
	output lzhd_cmd_t      cmd
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_FIN  = 4'd2;
	localparam logic [3:0] S_PASS = 4'd3;
	localparam logic [3:0] S_LIT  = 4'd4;
	localparam logic [3:0] S_DRD  = 4'd5;
	localparam logic [3:0] S_DCAP = 4'd6;
	localparam logic [3:0] S_MRD  = 4'd7;
	localparam logic [3:0] S_MOUT = 4'd8;
	localparam logic [3:0] S_H0   = 4'd9;
	localparam logic [3:0] S_H1   = 4'd10;
	localparam logic [3:0] S_H2   = 4'd11;
	localparam logic [3:0] S_H3   = 4'd12;
	localparam logic [3:0] S_H4   = 4'd13;
	localparam logic [3:0] S_H5   = 4'd14;
	localparam logic [3:0] S_FSET = 4'd15;

	localparam logic [1:0] PH_FLAG_LO = 2'd0;
	localparam logic [1:0] PH_FLAG_HI = 2'd1;
	localparam logic [1:0] PH_TOKEN   = 2'd2;
	localparam logic [1:0] PH_MATCH2  = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       lit_hash_q, lit_hash_d;
	logic       in_match_q, in_match_d;
	logic       jobs_q, jobs_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		phase_d = phase_q;
		lit_hash_d = lit_hash_q;
		in_match_d = in_match_q;
		jobs_d = jobs_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (st.pass) begin
						state_d = S_PASS;
					end else begin
						case (phase_q)
							PH_FLAG_LO: begin
								cmd.f_lo = 1'b1;
								phase_d = PH_FLAG_HI;
								state_d = S_FIN;
							end
							PH_FLAG_HI: begin
								cmd.f_hi = 1'b1;
								phase_d = PH_TOKEN;
								state_d = S_FIN;
							end
							PH_TOKEN: begin
								if (st.flag0) begin
									cmd.m1 = 1'b1;
									phase_d = PH_MATCH2;
									state_d = S_FIN;
								end else begin
									cmd.lit = 1'b1;
									phase_d = st.flag_last ? PH_FLAG_LO : PH_TOKEN;
									lit_hash_d = (st.lit_run == 2'd2);
									in_match_d = 1'b0;
									jobs_d = 1'b0;
									state_d = S_LIT;
								end
							end
							default: begin
								cmd.m2 = 1'b1;
								phase_d = st.flag_last ? PH_FLAG_LO : PH_TOKEN;
								in_match_d = 1'b1;
								state_d = S_DRD;
							end
						endcase
					end
				end
			end
			S_PASS: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_FIN;
				end
			end
			S_LIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = lit_hash_q ? S_H0 : S_FIN;
				end
			end
			S_DRD: begin
				cmd.dict_rd = 1'b1;
				state_d = S_DCAP;
			end
			S_DCAP: begin
				cmd.dict_cap = 1'b1;
				state_d = S_MRD;
			end
			S_MRD: begin
				cmd.m_rd = 1'b1;
				state_d = S_MOUT;
			end
			S_MOUT: begin
				out_valid = 1'b1;
				cmd.out_match = 1'b1;
				if (out_ready) begin
					cmd.m_xfer = 1'b1;
					if (st.match_end) begin
						if (st.lit_run != 2'd0) begin
							cmd.post = 1'b1;
							jobs_d = (st.lit_run == 2'd2);
							state_d = S_H0;
						end else begin
							state_d = S_FSET;
						end
					end else begin
						state_d = S_MRD;
					end
				end
			end
			S_H0: begin
				cmd.h_rd = 1'b1;
				state_d = S_H1;
			end
			S_H1: begin
				cmd.h_rd = 1'b1;
				cmd.h_cap = 1'b1;
				state_d = S_H2;
			end
			S_H2: begin
				cmd.h_rd = 1'b1;
				cmd.h_cap = 1'b1;
				state_d = S_H3;
			end
			S_H3: begin
				cmd.h_cap = 1'b1;
				state_d = S_H4;
			end
			S_H4: begin
				cmd.h_mul = 1'b1;
				state_d = S_H5;
			end
			S_H5: begin
				cmd.h_set = 1'b1;
				if (jobs_q) begin
					cmd.h_next = 1'b1;
					jobs_d = 1'b0;
					state_d = S_H0;
				end else begin
					state_d = in_match_q ? S_FSET : S_FIN;
				end
			end
			S_FSET: begin
				cmd.fin_set = 1'b1;
				state_d = S_FIN;
			end
			default: begin
				if (st.last) begin
					cmd.restart = 1'b1;
					phase_d = PH_FLAG_LO;
					state_d = S_CLR;
				end else begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			phase_q <= PH_FLAG_LO;
			lit_hash_q <= 1'b0;
			in_match_q <= 1'b0;
			jobs_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			lit_hash_q <= lit_hash_d;
			in_match_q <= in_match_d;
			jobs_q <= jobs_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lzhd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzhd_datapath import lzhd_pkg::*; #(
	parameter int HISTORY_DEPTH = 65536
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire in_item_t   in_data,
	input  wire lzhd_cmd_t  cmd,
	output lzhd_sts_t       st,
	output out_item_t       out_data
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int EW = 1 + POS_W + AW;
	localparam int DICT_N = 1 << DICT_AW;

	function automatic logic [AW-1:0] hsub(input logic [AW-1:0] a, input logic [1:0] k);
		logic [AW:0] t;
		t = {1'b0, a} - (AW+1)'(k);
		if (a < AW'(k)) begin
			t = t + (AW+1)'(HISTORY_DEPTH);
		end
		return t[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] hinc(input logic [AW-1:0] a);
		return (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	logic [7:0]         hist_mem [HISTORY_DEPTH];
	logic [7:0]         hist_rd_q;
	logic [EW-1:0]      dict_mem [DICT_N];
	logic [EW-1:0]      dict_rd_q;

	logic [7:0]         b_q;
	logic               last_q;
	logic [16:0]        flag_q;
	logic [7:0]         mf_q;
	logic [1:0]         lr_q;
	logic [2:0]         rotor_q;
	logic [POS_W-1:0]   pos_q;
	logic [AW-1:0]      hp_q;
	logic [DICT_AW-1:0] idx_q;
	logic [4:0]         len_q;
	logic [4:0]         i_q;
	logic [POS_W-1:0]   org_q;
	logic [AW-1:0]      horg_q;
	logic               dflt_q;
	logic               flt_q;
	logic [AW-1:0]      rh_q;
	logic [AW-1:0]      hb_q;
	logic [AW-1:0]      hr_q;
	logic [POS_W-1:0]   hpos_q;
	logic [7:0]         h0_q, h1_q, h2_q;
	logic [15:0]        prod_q;
	logic [DICT_AW-1:0] clr_q;

	logic [7:0]         mv;
	logic               h_ren;
	logic [AW-1:0]      h_raddr;
	logic               h_wen;
	logic [7:0]         h_wdata;
	logic               d_wen;
	logic [DICT_AW-1:0] d_waddr;
	logic [EW-1:0]      d_wdata;
	logic [15:0]        hv;
	logic               rot_adv;
	logic               e_dflt;
	logic [POS_W-1:0]   e_pos;

	assign mv = dflt_q ? default_char(i_q) : hist_rd_q;
	assign h_ren = cmd.m_rd | cmd.h_rd;
	assign h_raddr = cmd.m_rd ? rh_q : hr_q;
	assign h_wen = cmd.lit | cmd.m_xfer;
	assign h_wdata = cmd.lit ? in_data.in_byte : mv;
	assign hv = {h0_q, 8'h00} ^ {4'h0, h1_q, 4'h0} ^ {8'h00, h2_q};
	assign e_dflt = dict_rd_q[EW-1];
	assign e_pos = dict_rd_q[EW-2 -: POS_W];
	assign rot_adv = (cmd.h_set | cmd.fin_set) && (mode != MODE_DIRECT);

	always_comb begin
		d_wen = 1'b1;
		d_waddr = clr_q;
		d_wdata = {1'b1, {(EW-1){1'b0}}};
		if (cmd.clr) begin
			d_waddr = clr_q;
		end else if (cmd.h_set) begin
			d_waddr = (mode == MODE_DIRECT) ? prod_q[15:4] : {prod_q[12:4], rotor_q};
			d_wdata = {1'b0, hpos_q, hb_q};
		end else if (cmd.fin_set) begin
			d_waddr = (mode == MODE_DIRECT) ? idx_q : {idx_q[11:3], rotor_q};
			d_wdata = {1'b0, org_q, horg_q};
		end else begin
			d_wen = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (h_wen) begin
			hist_mem[hp_q] <= h_wdata;
		end
		if (h_ren) begin
			hist_rd_q <= hist_mem[h_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (d_wen) begin
			dict_mem[d_waddr] <= d_wdata;
		end
		if (cmd.dict_rd) begin
			dict_rd_q <= dict_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 17'd1;
			mf_q <= '0;
			lr_q <= '0;
			rotor_q <= '0;
			pos_q <= '0;
			hp_q <= '0;
			clr_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				flag_q <= 17'd1;
				mf_q <= '0;
				lr_q <= '0;
				rotor_q <= '0;
				pos_q <= '0;
				hp_q <= '0;
				clr_q <= '0;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.take) begin
				last_q <= in_data.last_byte;
			end
			if (cmd.f_lo) begin
				flag_q <= {1'b1, 8'h00, in_data.in_byte};
			end
			if (cmd.f_hi) begin
				flag_q <= {flag_q[16], in_data.in_byte, flag_q[7:0]};
			end
			if (cmd.m1) begin
				mf_q <= in_data.in_byte;
			end
			if (cmd.lit) begin
				pos_q <= pos_q + 1'b1;
				hp_q <= hinc(hp_q);
				flag_q <= {1'b0, flag_q[16:1]};
				if (lr_q != 2'd2) begin
					lr_q <= lr_q + 1'b1;
				end
			end
			if (cmd.m2) begin
				flag_q <= {1'b0, flag_q[16:1]};
			end
			if (cmd.m_xfer) begin
				pos_q <= pos_q + 1'b1;
				hp_q <= hinc(hp_q);
			end
			if (cmd.post) begin
				lr_q <= '0;
			end
			if (rot_adv) begin
				rotor_q <= rotor_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			b_q <= in_data.in_byte;
		end
		if (cmd.lit && lr_q == 2'd2) begin
			hb_q <= hsub(hp_q, 2'd2);
			hr_q <= hsub(hp_q, 2'd2);
			hpos_q <= pos_q - POS_W'(2);
		end
		if (cmd.m2) begin
			idx_q <= {mf_q[7:4], in_data.in_byte};
			len_q <= {1'b0, mf_q[3:0]} + 5'd3;
			org_q <= pos_q;
			horg_q <= hp_q;
			i_q <= '0;
		end
		if (cmd.dict_cap) begin
			dflt_q <= e_dflt;
			rh_q <= dict_rd_q[AW-1:0];
			flt_q <= !e_dflt && ((org_q - e_pos) > POS_W'(HISTORY_DEPTH));
		end
		if (cmd.m_xfer) begin
			rh_q <= hinc(rh_q);
			i_q <= i_q + 1'b1;
		end
		if (cmd.post) begin
			hb_q <= hsub(horg_q, lr_q);
			hr_q <= hsub(horg_q, lr_q);
			hpos_q <= org_q - POS_W'(lr_q);
		end
		if (cmd.h_rd) begin
			hr_q <= hinc(hr_q);
		end
		if (cmd.h_cap) begin
			h0_q <= h1_q;
			h1_q <= h2_q;
			h2_q <= hist_rd_q;
		end
		if (cmd.h_mul) begin
			prod_q <= 16'(hv * HASH_MULT);
		end
		if (cmd.h_next) begin
			hb_q <= hinc(hb_q);
			hr_q <= hinc(hb_q);
			hpos_q <= hpos_q + 1'b1;
		end
	end

	assign st.clr_done = (clr_q == {DICT_AW{1'b1}});
	assign st.flag0 = flag_q[0];
	assign st.flag_last = (flag_q[16:1] == 16'd1);
	assign st.lit_run = lr_q;
	assign st.match_end = (i_q == len_q - 5'd1);
	assign st.last = last_q;
	assign st.pass = (mode == MODE_PASS);

	always_comb begin
		if (cmd.out_match) begin
			out_data.out_byte = mv;
			out_data.run_last = st.match_end;
			out_data.fault = flt_q;
		end else begin
			out_data.out_byte = b_q;
			out_data.run_last = 1'b1;
			out_data.fault = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lz_hash_dictionary_decoder.sv =====
// Sequencing: a literal's input is taken in S_IDLE and its byte offered in S_LIT; a match's
//   first byte is offered after its second input byte via S_DRD, S_DCAP, S_MRD and S_MOUT,
//   then each further byte passes S_MRD and S_MOUT again (one history read port).
// One item at a time; a flag byte or first match byte passes S_FIN, a literal from the third in a
//   row on is hashed (S_H0 to S_H5), a match hashes once per pending literal; output stalls hold it.
// Reset and end of stream: a dictionary clearing pass over every entry, no input taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module lz_hash_dictionary_decoder import lzhd_pkg::*; #(
	parameter int HISTORY_DEPTH = 65536
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_data
);

	logic [1:0] mode_q;
	lzhd_cmd_t  cmd;
	lzhd_sts_t  st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DIRECT;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	lzhd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	lzhd_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.in_data  (in_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer accepted back to back");

	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode_q == MODE_PASS && !cmd.out_match) |-> out_data.run_last)
		else $error("passthrough result without run_last");
`endif

endmodule

`default_nettype wire
